>>> hw/rtl/ovle_pkg.sv
// ----------------------------------------------------------------------------
// ovle_pkg
// shared types and constants of the ordered value list engine
// ----------------------------------------------------------------------------
package ovle_pkg;

    // capacity of the value store, 2 to 64
    localparam int LIST_DEPTH  = 16;
    localparam int IDXW        = $clog2(LIST_DEPTH);
    localparam int CNTW        = $clog2(LIST_DEPTH + 1);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTRW       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNTW       = $clog2(QUEUE_DEPTH + 1);

    localparam int VALW        = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_LIST   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_LISTED    = 3'd4
    } t_status;

    typedef struct packed {
        t_op              op;
        logic [VALW-1:0]  value;
    } t_cmd;

endpackage

>>> hw/rtl/ovle_front.sv
// ----------------------------------------------------------------------------
// ovle_front
// input register and opcode decode, feeds the command queue
// ----------------------------------------------------------------------------
module ovle_front
    import ovle_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_opcode,
    input  logic [VALW-1:0] i_value,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready,
    output t_cmd            o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_op  dec_op;

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // every 2-bit code is a valid opcode
    assign dec_op = t_op'(i_opcode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd.op    <= dec_op;
            r_cmd.value <= i_value;
        end
    end

endmodule

>>> hw/rtl/ovle_queue.sv
// ----------------------------------------------------------------------------
// ovle_queue
// small command queue that decouples front and back
// ----------------------------------------------------------------------------
module ovle_queue
    import ovle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [QPTRW-1:0] r_wr;
    logic [QPTRW-1:0] r_rd;
    logic [QCNTW-1:0] r_fill;
    logic             push;
    logic             pop;

    assign o_ready = (r_fill != QCNTW'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_slot[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QPTRW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTRW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == QPTRW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTRW'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + QCNTW'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - QCNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

endmodule

>>> hw/rtl/ovle_back.sv
// ----------------------------------------------------------------------------
// ovle_back
// value store, list walker and result register
// ----------------------------------------------------------------------------
module ovle_back
    import ovle_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_ready,
    input  t_cmd            i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output t_status         o_status,
    output logic [VALW-1:0] o_value,
    output logic            o_last
);

    localparam int EW = CNTW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_LIST,
        S_REPLY
    } t_state;

    t_state          r_state;
    logic [IDXW-1:0] r_idx;
    logic [CNTW-1:0] r_count;
    logic [VALW-1:0] r_val;
    logic            r_is_del;
    t_status         r_status;
    logic            r_out_valid;
    t_status         r_out_status;
    logic [VALW-1:0] r_out_value;
    logic            r_out_last;

    logic [VALW-1:0] mem [LIST_DEPTH];
    logic [VALW-1:0] r_rdata;

    logic            out_free;
    logic            out_load;
    logic            full;
    logic            hit;
    logic [EW-1:0]   idx_w;
    logic [EW-1:0]   cnt_w;
    logic            scan_more;
    logic            shift_more;
    logic            list_last;
    logic [IDXW-1:0] idx_nxt;
    logic [IDXW-1:0] rd_addr;
    logic            we;
    logic [IDXW-1:0] waddr;
    logic [VALW-1:0] wdata;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_value     = r_out_value;
    assign o_last      = r_out_last;

    assign out_free   = !r_out_valid || i_ready;
    assign out_load   = out_free && (r_state == S_LIST || r_state == S_REPLY);
    assign full       = (r_count == CNTW'(LIST_DEPTH));
    assign hit        = (r_rdata == r_val);
    assign idx_w      = EW'(r_idx);
    assign cnt_w      = EW'(r_count);
    assign scan_more  = (idx_w + EW'(1)) < cnt_w;
    assign shift_more = (idx_w + EW'(2)) < cnt_w;
    assign list_last  = (idx_w + EW'(1)) == cnt_w;
    assign idx_nxt    = r_idx + IDXW'(1);

    // read address: one entry ahead of the walk
    always_comb begin
        unique case (r_state)
            S_SCAN:  rd_addr = idx_nxt;
            S_SHIFT: rd_addr = idx_nxt + IDXW'(1);
            S_LIST:  rd_addr = (out_free && !list_last) ? idx_nxt : r_idx;
            default: rd_addr = '0;
        endcase
    end

    // write port: tail append or one step of closing the gap
    always_comb begin
        we    = 1'b0;
        waddr = r_count[IDXW-1:0];
        wdata = i_cmd.value;
        if (r_state == S_IDLE && i_cmd_valid && i_cmd.op == OP_INSERT && !full) begin
            we = 1'b1;
        end else if (r_state == S_SHIFT) begin
            we    = 1'b1;
            waddr = r_idx;
            wdata = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_val    <= i_cmd.value;
                        r_is_del <= (i_cmd.op == OP_DELETE);
                        r_idx    <= '0;
                        unique case (i_cmd.op)
                            OP_INSERT: begin
                                r_state <= S_REPLY;
                                if (full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_status <= ST_OK;
                                    r_count  <= r_count + CNTW'(1);
                                end
                            end
                            OP_SEARCH, OP_DELETE: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_REPLY;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_REPLY;
                                end else begin
                                    r_state <= S_LIST;
                                end
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_status <= ST_OK;
                        if (r_is_del && scan_more) begin
                            r_state <= S_SHIFT;
                        end else begin
                            if (r_is_del) begin
                                r_count <= r_count - CNTW'(1);
                            end
                            r_state <= S_REPLY;
                        end
                    end else if (scan_more) begin
                        r_idx <= idx_nxt;
                    end else begin
                        r_status <= ST_NOT_FOUND;
                        r_state  <= S_REPLY;
                    end
                end
                S_SHIFT: begin
                    if (shift_more) begin
                        r_idx <= idx_nxt;
                    end else begin
                        r_count <= r_count - CNTW'(1);
                        r_state <= S_REPLY;
                    end
                end
                S_LIST: begin
                    if (out_free) begin
                        r_out_status <= ST_LISTED;
                        r_out_value  <= r_rdata;
                        r_out_last   <= list_last;
                        if (list_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= idx_nxt;
                        end
                    end
                end
                default: begin
                    if (out_free) begin
                        r_out_status <= r_status;
                        r_out_value  <= '0;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/ordered_value_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_value_list_engine
// ordered list of signed 32-bit values: append, search, delete, list
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                    tdata        tuser       tlast
//  s_axis    in   i_s_axis_tvalid/o_..tready   value[31:0]  opcode[1:0] -
//  m_axis    out  o_m_axis_tvalid/i_..tready   item_value   status[2:0] last
//
//  insert passes the front register, the command queue and the back's
//  reply state on its way to the result register; search reads one entry
//  per cycle through the single read port of the value store; delete then
//  moves each entry behind the match down one place; list gives its words
//  one per cycle while the result register is free to take them
//  reset is synchronous and active low and empties the list at once
//  either side may stall alone: the command queue keeps the front taking
//  words, until the queue fills, while the back walks the store or waits
//  on the result register
module ordered_value_list_engine
    import ovle_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    // input words
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  logic [31:0]     i_s_axis_tdata,   // value[31:0]
    input  logic [1:0]      i_s_axis_tuser,   // opcode[1:0]
    // result words
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    output logic [31:0]     o_m_axis_tdata,   // item_value[31:0]
    output logic [2:0]      o_m_axis_tuser,   // status[2:0]
    output logic            o_m_axis_tlast
);

    // front to queue
    logic    f_valid;
    logic    f_ready;
    t_cmd    f_cmd;
    // queue to back
    logic    q_valid;
    logic    q_ready;
    t_cmd    q_cmd;
    t_status b_status;

    // accepts and decodes words
    ovle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_opcode    (i_s_axis_tuser),
        .i_value     (i_s_axis_tdata),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    // decoupling queue
    ovle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_cmd   (f_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    // carries out commands on the store
    ovle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_status    (b_status),
        .o_value     (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = b_status;

endmodule
